### hdl/assert_macros.svh
// Shared concurrent assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/twbpd_pkg.sv
package twbpd_pkg;

   localparam int PitchW  = 17;
   localparam int GyroW   = 16;
   localparam int GainW   = 16;
   localparam int GearW   = 3;
   localparam int TiltW   = 16;
   localparam int DutyW   = 12;
   localparam int IntegW  = 19;
   localparam int SmoothW = 12;
   localparam int RampW   = 10;
   localparam int DivW    = 2;
   localparam int AddrW   = 5;
   localparam int DataW   = 32;
   localparam int SumW    = 42;
   localparam int ClampW  = 28;

   typedef enum logic [2:0] {
      REG_GAIN_PROP   = 3'd0,
      REG_GAIN_INTEG  = 3'd1,
      REG_GAIN_RATE   = 3'd2,
      REG_SPEED_GEAR  = 3'd3,
      REG_TILT_CUTOFF = 3'd4,
      REG_RAMP_TILT   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [GainW-1:0] gain_prop;
      logic [GainW-1:0] gain_integ;
      logic [GainW-1:0] gain_rate;
      logic [GearW-1:0] speed_gear;
      logic [TiltW-1:0] tilt_cutoff;
      logic [TiltW-1:0] ramp_tilt;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      gain_prop:   16'd25600,
      gain_integ:  16'd0,
      gain_rate:   16'd13,
      speed_gear:  3'd4,
      tilt_cutoff: 16'd12800,
      ramp_tilt:   16'd1280
   };

   // Integrator limit is 1000 degrees in Q8.8; drive limit is 1500 in Q16.16.
   localparam logic signed [IntegW-1:0] IntegLim    = 19'sd256000;
   localparam logic signed [IntegW-1:0] IntegLimNeg = -19'sd256000;
   localparam logic signed [SumW-1:0]   DriveLim    = 42'sd98304000;
   localparam logic signed [SumW-1:0]   DriveLimNeg = -42'sd98304000;

   // floor(x * 6554 / 65536) equals floor(x / 10) for every x up to 16000.
   localparam logic [12:0] Recip10 = 13'd6554;

   localparam logic [RampW-1:0] RampMax = 10'd600;
   localparam logic [DutyW-1:0] DutyMax = 12'd2100;

   function automatic logic [RampW-1:0] gear_limit(input logic [GearW-1:0] gear);
      logic [RampW-1:0] lim;
      case (gear)
         3'd1: begin
            lim = 10'd300;
         end
         3'd2: begin
            lim = 10'd400;
         end
         3'd3: begin
            lim = 10'd500;
         end
         3'd4: begin
            lim = 10'd600;
         end
         default: begin
            lim = 10'd400;
         end
      endcase
      return lim;
   endfunction

endpackage

### hdl/twbpd_req_if.sv
interface twbpd_req_if import twbpd_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [PitchW-1:0] pitch_left;
   logic signed [PitchW-1:0] pitch_right;
   logic signed [GyroW-1:0]  gyro_left;
   logic signed [GyroW-1:0]  gyro_right;
   logic                     armed;

   modport source (
      output valid, pitch_left, pitch_right, gyro_left, gyro_right, armed,
      input  ready
   );

   modport sink (
      input  valid, pitch_left, pitch_right, gyro_left, gyro_right, armed,
      output ready
   );
endinterface

### hdl/twbpd_rsp_if.sv
interface twbpd_rsp_if import twbpd_pkg::*;;
   logic             valid;
   logic             ready;
   logic [DutyW-1:0] duty_left;
   logic [DutyW-1:0] duty_right;
   logic             dir_left;
   logic             dir_right;

   modport source (
      output valid, duty_left, duty_right, dir_left, dir_right,
      input  ready
   );

   modport sink (
      input  valid, duty_left, duty_right, dir_left, dir_right,
      output ready
   );
endinterface

### hdl/twbpd_csr.sv
module twbpd_csr import twbpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [DataW-1:0] pwdata,
   output logic [DataW-1:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[AddrW-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_GAIN_PROP: begin
               cfg_in.gain_prop = pwdata[GainW-1:0];
            end
            REG_GAIN_INTEG: begin
               cfg_in.gain_integ = pwdata[GainW-1:0];
            end
            REG_GAIN_RATE: begin
               cfg_in.gain_rate = pwdata[GainW-1:0];
            end
            REG_SPEED_GEAR: begin
               cfg_in.speed_gear = pwdata[GearW-1:0];
            end
            REG_TILT_CUTOFF: begin
               cfg_in.tilt_cutoff = pwdata[TiltW-1:0];
            end
            REG_RAMP_TILT: begin
               cfg_in.ramp_tilt = pwdata[TiltW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GAIN_PROP: begin
            prdata = DataW'(cfg_ff.gain_prop);
         end
         REG_GAIN_INTEG: begin
            prdata = DataW'(cfg_ff.gain_integ);
         end
         REG_GAIN_RATE: begin
            prdata = DataW'(cfg_ff.gain_rate);
         end
         REG_SPEED_GEAR: begin
            prdata = DataW'(cfg_ff.speed_gear);
         end
         REG_TILT_CUTOFF: begin
            prdata = DataW'(cfg_ff.tilt_cutoff);
         end
         REG_RAMP_TILT: begin
            prdata = DataW'(cfg_ff.ramp_tilt);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/twbpd_wheel.sv
module twbpd_wheel import twbpd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      upd_pid,
   input  logic                      load_drive,
   input  logic                      upd_smooth,
   input  logic signed [PitchW-1:0]  pitch,
   input  logic signed [GyroW-1:0]   gyro,
   input  cfg_type                   cfg,
   output logic signed [SmoothW-1:0] smooth_new
);

   logic signed [IntegW-1:0]   integ_ff;
   logic signed [IntegW-1:0]   integ_in;
   logic signed [SmoothW-1:0]  smooth_ff;
   logic signed [SmoothW-1:0]  smooth_in;
   logic signed [SmoothW-1:0]  drive_ff;
   logic signed [SmoothW-1:0]  drive_in;

   logic signed [IntegW:0]     acc_raw;
   logic signed [33:0]         p_prop;
   logic signed [35:0]         p_integ;
   logic signed [32:0]         p_rate;
   logic signed [SumW-1:0]     sum;
   logic signed [SumW-1:0]     sum_clamp;
   logic signed [ClampW-1:0]   clamp_n;
   logic signed [ClampW-1:0]   clamp_abs;
   logic [10:0]                drive_mag;
   logic signed [15:0]         blend;
   logic signed [15:0]         blend_neg;
   logic [13:0]                blend_mag;
   logic [26:0]                tenth_prod;
   logic [10:0]                tenth;

   // Integrator accumulates pitch and saturates at 1000 degrees either way.
   always_comb begin
      acc_raw = (IntegW+1)'(integ_ff) + (IntegW+1)'(pitch);
      if (acc_raw > (IntegW+1)'(IntegLim)) begin
         integ_in = IntegLim;
      end else if (acc_raw < (IntegW+1)'(IntegLimNeg)) begin
         integ_in = IntegLimNeg;
      end else begin
         integ_in = acc_raw[IntegW-1:0];
      end
   end

   assign p_prop  = pitch * $signed({1'b0, cfg.gain_prop});
   assign p_integ = integ_in * $signed({1'b0, cfg.gain_integ});
   assign p_rate  = gyro * $signed({1'b0, cfg.gain_rate});
   assign sum     = SumW'(p_prop) + SumW'(p_integ) + (SumW'(p_rate) <<< 8);

   // Saturate the Q16.16 sum, drop the fraction toward zero, and negate.
   always_comb begin
      if (sum > DriveLim) begin
         sum_clamp = DriveLim;
      end else if (sum < DriveLimNeg) begin
         sum_clamp = DriveLimNeg;
      end else begin
         sum_clamp = sum;
      end
      clamp_n   = sum_clamp[ClampW-1:0];
      clamp_abs = clamp_n[ClampW-1] ? -clamp_n : clamp_n;
      drive_mag = clamp_abs[26:16];
      if (clamp_n[ClampW-1]) begin
         drive_in = $signed({1'b0, drive_mag});
      end else begin
         drive_in = -$signed({1'b0, drive_mag});
      end
   end

   // Smoothing (9*last + new) / 10 with truncation toward zero.
   always_comb begin
      blend      = (16'(smooth_ff) <<< 3) + 16'(smooth_ff) + 16'(drive_ff);
      blend_neg  = -blend;
      blend_mag  = blend[15] ? blend_neg[13:0] : blend[13:0];
      tenth_prod = 27'(blend_mag) * 27'(Recip10);
      tenth      = tenth_prod[26:16];
      if (blend[15]) begin
         smooth_in = -$signed({1'b0, tenth});
      end else begin
         smooth_in = $signed({1'b0, tenth});
      end
   end

   assign smooth_new = smooth_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff  <= '0;
         smooth_ff <= '0;
      end else begin
         if (upd_pid) begin
            integ_ff <= integ_in;
         end
         if (upd_smooth) begin
            smooth_ff <= smooth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_drive) begin
         drive_ff <= drive_in;
      end
   end

endmodule

### hdl/two_wheel_balance_pid_drive.sv
// An accepted request moves through the first-stage and second-stage registers into the
// result register unless the result channel stalls. Throughput: one request per cycle
// when not stalled. The first stage runs the PID and the integrators, the
// second the smoothing, ramp and duty, each stage updating its own state as an item leaves.
// Reset (synchronous, active high) empties all three registers, zeroes integrators,
// smoothing, ramp, divider and held directions, and loads register defaults.
`include "assert_macros.svh"

module two_wheel_balance_pid_drive import twbpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   twbpd_req_if.sink        req,
   twbpd_rsp_if.source      rsp,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [DataW-1:0] pwdata,
   output logic [DataW-1:0] prdata,
   output logic             pready
);

   cfg_type cfg;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic signed [PitchW-1:0]  pitch_l_ff;
   logic signed [PitchW-1:0]  pitch_r_ff;
   logic signed [GyroW-1:0]   gyro_l_ff;
   logic signed [GyroW-1:0]   gyro_r_ff;
   logic                      armed_ff;

   logic                      s2_valid_ff;
   logic                      s2_valid_in;
   logic                      armed_s2_ff;
   logic [PitchW-1:0]         tilt_l_ff;
   logic [PitchW-1:0]         tilt_r_ff;
   logic [PitchW-1:0]         tilt_l_in;
   logic [PitchW-1:0]         tilt_r_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [DutyW-1:0]          duty_l_ff;
   logic [DutyW-1:0]          duty_r_ff;
   logic                      dir_l_ff;
   logic                      dir_r_ff;
   logic [DutyW-1:0]          duty_l_in;
   logic [DutyW-1:0]          duty_r_in;

   logic [RampW-1:0]          ramp_ff;
   logic [RampW-1:0]          ramp_in;
   logic [DivW-1:0]           div_ff;
   logic [DivW-1:0]           div_in;
   logic                      hold_l_ff;
   logic                      hold_l_in;
   logic                      hold_r_ff;
   logic                      hold_r_in;

   logic                      adv;
   logic                      adv_s1;
   logic                      upd_pid;
   logic                      upd_smooth;
   logic                      upd_ramp;
   logic                      stand;
   logic                      ramp_up;
   logic signed [SmoothW-1:0] smooth_l;
   logic signed [SmoothW-1:0] smooth_r;
   logic [SmoothW-1:0]        smag_l;
   logic [SmoothW-1:0]        smag_r;

   twbpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Each stage moves on whenever the stage after it is free or drains in the same cycle.
   assign adv          = s2_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign adv_s1       = s1_valid_ff && (!s2_valid_ff || adv);
   assign req.ready    = !s1_valid_ff || adv_s1;
   assign s1_valid_in  = (req.valid && req.ready) || (s1_valid_ff && !adv_s1);
   assign s2_valid_in  = adv_s1 || (s2_valid_ff && !adv);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp.ready);

   assign upd_pid    = adv_s1 && armed_ff;
   assign upd_smooth = adv && armed_s2_ff;

   twbpd_wheel u_wheel_l (
      .clock      (clock),
      .reset      (reset),
      .upd_pid    (upd_pid),
      .load_drive (adv_s1),
      .upd_smooth (upd_smooth),
      .pitch      (pitch_l_ff),
      .gyro       (gyro_l_ff),
      .cfg        (cfg),
      .smooth_new (smooth_l)
   );

   twbpd_wheel u_wheel_r (
      .clock      (clock),
      .reset      (reset),
      .upd_pid    (upd_pid),
      .load_drive (adv_s1),
      .upd_smooth (upd_smooth),
      .pitch      (pitch_r_ff),
      .gyro       (gyro_r_ff),
      .cfg        (cfg),
      .smooth_new (smooth_r)
   );

   // The most negative pitch negates to its own bit pattern, which reads right unsigned.
   assign tilt_l_in = pitch_l_ff[PitchW-1] ? PitchW'(-pitch_l_ff) : PitchW'(pitch_l_ff);
   assign tilt_r_in = pitch_r_ff[PitchW-1] ? PitchW'(-pitch_r_ff) : PitchW'(pitch_r_ff);

   assign stand = armed_s2_ff && (tilt_l_ff < PitchW'(cfg.tilt_cutoff))
                  && (tilt_r_ff < PitchW'(cfg.tilt_cutoff));
   assign ramp_up = (tilt_l_ff > PitchW'(cfg.ramp_tilt))
                    && (tilt_r_ff > PitchW'(cfg.ramp_tilt));
   assign upd_ramp = adv && stand;

   // The ramp climbs once every second tick while ramping and decays by one otherwise.
   always_comb begin
      ramp_in = ramp_ff;
      div_in  = div_ff;
      if (ramp_up) begin
         if (div_ff > 2'd1) begin
            div_in = 2'd1;
            if (ramp_ff < gear_limit(cfg.speed_gear)) begin
               ramp_in = ramp_ff + RampW'(1);
            end
         end else begin
            div_in = div_ff + DivW'(1);
         end
      end else if (ramp_ff != '0) begin
         ramp_in = ramp_ff - RampW'(1);
      end
   end

   assign smag_l = smooth_l[SmoothW-1] ? SmoothW'(-smooth_l) : SmoothW'(smooth_l);
   assign smag_r = smooth_r[SmoothW-1] ? SmoothW'(-smooth_r) : SmoothW'(smooth_r);

   assign hold_l_in = stand ? (smooth_l > 0) : hold_l_ff;
   assign hold_r_in = stand ? !(smooth_r > 0) : hold_r_ff;

   assign duty_l_in = stand ? (smag_l + DutyW'(ramp_in)) : '0;
   assign duty_r_in = stand ? (smag_r + DutyW'(ramp_in)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ramp_ff      <= '0;
         div_ff       <= '0;
         hold_l_ff    <= 1'b0;
         hold_r_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_ramp) begin
            ramp_ff   <= ramp_in;
            div_ff    <= div_in;
            hold_l_ff <= hold_l_in;
            hold_r_ff <= hold_r_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         pitch_l_ff <= req.pitch_left;
         pitch_r_ff <= req.pitch_right;
         gyro_l_ff  <= req.gyro_left;
         gyro_r_ff  <= req.gyro_right;
         armed_ff   <= req.armed;
      end
      if (adv_s1) begin
         armed_s2_ff <= armed_ff;
         tilt_l_ff   <= tilt_l_in;
         tilt_r_ff   <= tilt_r_in;
      end
      if (adv) begin
         duty_l_ff <= duty_l_in;
         duty_r_ff <= duty_r_in;
         dir_l_ff  <= hold_l_in;
         dir_r_ff  <= hold_r_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.duty_left  = duty_l_ff;
   assign rsp.duty_right = duty_r_ff;
   assign rsp.dir_left   = dir_l_ff;
   assign rsp.dir_right  = dir_r_ff;

   `ASSERT_IMP(a_ramp_cap, clock, reset, 1'b1, ramp_ff <= RampMax)
   `ASSERT_IMP(a_duty_cap, clock, reset, rsp_valid_ff,
      (duty_l_ff <= DutyMax) && (duty_r_ff <= DutyMax))
   `ASSERT_NXT(a_disarmed_hold, clock, reset, adv && !armed_s2_ff,
      $stable(ramp_ff) && $stable(div_ff) && (duty_l_ff == '0) && (duty_r_ff == '0))

endmodule
